// File: rtl/hash_map_key_value_table_macros.svh
// Assertion macros for the key-value table engine.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef HASH_MAP_KEY_VALUE_TABLE_MACROS_SVH
`define HASH_MAP_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define HMKV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define HMKV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hmkv_pkg.sv
// Shared constants, types and opcodes of the key-value table engine.
// Depends on nothing; used by every other file of the block but the macro header.
package hmkv_pkg;

    localparam int OP_W        = 2;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    // Bucket count must stay a power of two: the hash reduction is a bit slice.
    localparam int NUM_BUCKETS = 1024;
    localparam int BUCKET_WAYS = 4;
    localparam int BUCKET_BITS = $clog2(NUM_BUCKETS);
    localparam int WAY_BITS    = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int HASH_SHIFT  = 16;
    // Only the product bits up to the top bucket bit matter.
    localparam int PROD_W      = HASH_SHIFT + BUCKET_BITS;

    localparam logic [KEY_W-1:0] HASH_MULT  = 32'h9E37_79B9;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [BUCKET_WAYS-1:0]             valid;
        logic [BUCKET_WAYS-1:0][KEY_W-1:0]  keys;
        logic [BUCKET_WAYS-1:0][VAL_W-1:0]  values;
    } t_row;

    typedef struct packed {
        logic idle;   // take a request
        logic clear;  // write one empty row of the clearing pass
        logic read;   // read the bucket row
        logic exec;   // compare, write back, load the result
    } t_cmd;

    typedef struct packed {
        logic req_valid;
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

// File: rtl/hmkv_if.sv
// Request and response channel interfaces of the key-value table engine.
// Depends on hmkv_pkg for field widths.
interface hmkv_req_if;
    logic                               valid;
    logic                               ready;
    logic [hmkv_pkg::OP_W-1:0]          op;
    logic signed [hmkv_pkg::KEY_W-1:0]  key;
    logic signed [hmkv_pkg::VAL_W-1:0]  value;

    modport source (output valid, op, key, value, input ready);
    modport sink   (input valid, op, key, value, output ready);
endinterface

interface hmkv_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [hmkv_pkg::VAL_W-1:0]  value_out;
    logic                               found;
    logic                               bucket_full;

    modport source (output valid, value_out, found, bucket_full, input ready);
    modport sink   (input valid, value_out, found, bucket_full, output ready);
endinterface

// File: rtl/hmkv_ctrl.sv
// Controller of the key-value table engine: clearing pass, then accept/read/execute.
// Depends on hmkv_pkg and the assertion macro header.
`include "hash_map_key_value_table_macros.svh"

module hmkv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmkv_pkg::t_status i_status,
    output hmkv_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EXEC  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_status.req_valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                // hold until the result register can take the new transaction
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.idle  = (r_state == ST_IDLE);
        o_cmd.clear = (r_state == ST_CLEAR);
        o_cmd.read  = (r_state == ST_READ);
        o_cmd.exec  = (r_state == ST_EXEC) && i_status.out_free;
    end

    `HMKV_ASSERT_NXT(a_accept_reads, i_clk, i_rst_n,
        (r_state == ST_IDLE) && i_status.req_valid, r_state == ST_READ,
        "accepted request did not move to bucket read")
    `HMKV_ASSERT_NXT(a_exec_stalls, i_clk, i_rst_n,
        (r_state == ST_EXEC) && !i_status.out_free, r_state == ST_EXEC,
        "execute step left while result register busy")
    `HMKV_ASSERT_NXT(a_clear_ends, i_clk, i_rst_n,
        (r_state == ST_CLEAR) && i_status.clr_last, r_state == ST_IDLE,
        "clearing pass did not end at the last row")
    `HMKV_ASSERT_IMP(a_exec_after_read, i_clk, i_rst_n,
        r_state == ST_EXEC,
        ($past(r_state) == ST_READ) || ($past(r_state) == ST_EXEC),
        "execute step entered without a bucket read")

endmodule

// File: rtl/hmkv_dpath.sv
// Datapath of the key-value table engine: hash, bucket row memory, way compare,
// write back and result register. Depends on hmkv_pkg and hmkv_if.
module hmkv_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmkv_pkg::t_cmd    i_cmd,
    output hmkv_pkg::t_status o_status,
    hmkv_req_if.sink          i_req,
    hmkv_rsp_if.source        o_rsp
);

    logic [hmkv_pkg::OP_W-1:0]        r_op;
    logic [hmkv_pkg::KEY_W-1:0]       r_key;
    logic [hmkv_pkg::VAL_W-1:0]       r_value;
    logic [hmkv_pkg::BUCKET_BITS-1:0] r_bucket;
    logic [hmkv_pkg::BUCKET_BITS-1:0] r_clr_idx;
    hmkv_pkg::t_row                   r_mem [hmkv_pkg::NUM_BUCKETS];
    hmkv_pkg::t_row                   r_rd_row;
    logic                             r_out_valid;
    logic [hmkv_pkg::VAL_W-1:0]       r_out_value;
    logic                             r_out_found;
    logic                             r_out_full;

    logic [hmkv_pkg::PROD_W-1:0]      w_key_lo;
    logic [hmkv_pkg::PROD_W-1:0]      w_prod;
    logic                             w_hit;
    logic [hmkv_pkg::WAY_BITS-1:0]    w_hit_way;
    logic                             w_free;
    logic [hmkv_pkg::WAY_BITS-1:0]    w_free_way;
    hmkv_pkg::t_row                   w_new_row;
    logic                             w_row_wr;
    logic                             w_wr_en;
    logic [hmkv_pkg::BUCKET_BITS-1:0] w_wr_addr;
    hmkv_pkg::t_row                   w_wr_row;
    logic                             w_take;

    assign w_take = i_cmd.idle && i_req.valid;

    // Low product bits do not depend on the sign extension of either operand.
    assign w_key_lo = i_req.key[hmkv_pkg::PROD_W-1:0];
    assign w_prod   = w_key_lo * hmkv_pkg::HASH_MULT[hmkv_pkg::PROD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op     <= i_req.op;
            r_key    <= i_req.key;
            r_value  <= i_req.value;
            r_bucket <= w_prod[hmkv_pkg::PROD_W-1:hmkv_pkg::HASH_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Find the first matching valid way and the first free way.
    always_comb begin
        w_hit      = 1'b0;
        w_hit_way  = '0;
        w_free     = 1'b0;
        w_free_way = '0;
        for (int w = 0; w < hmkv_pkg::BUCKET_WAYS; w++) begin
            if (r_rd_row.valid[w]) begin
                if (!w_hit && (r_rd_row.keys[w] == r_key)) begin
                    w_hit     = 1'b1;
                    w_hit_way = hmkv_pkg::WAY_BITS'(w);
                end
            end else if (!w_free) begin
                w_free     = 1'b1;
                w_free_way = hmkv_pkg::WAY_BITS'(w);
            end
        end
    end

    always_comb begin
        w_new_row = r_rd_row;
        w_row_wr  = 1'b0;
        if (r_op == hmkv_pkg::OP_PUT) begin
            if (w_hit) begin
                w_new_row.values[w_hit_way] = r_value;
                w_row_wr = 1'b1;
            end else if (w_free) begin
                w_new_row.keys[w_free_way]   = r_key;
                w_new_row.values[w_free_way] = r_value;
                w_new_row.valid[w_free_way]  = 1'b1;
                w_row_wr = 1'b1;
            end
        end else if (r_op == hmkv_pkg::OP_REMOVE) begin
            if (w_hit) begin
                w_new_row.valid[w_hit_way] = 1'b0;
                w_row_wr = 1'b1;
            end
        end
    end

    assign w_wr_en   = i_cmd.clear || (i_cmd.exec && w_row_wr);
    assign w_wr_addr = i_cmd.clear ? r_clr_idx : r_bucket;
    assign w_wr_row  = i_cmd.clear ? '0 : w_new_row;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_row;
        end
        if (i_cmd.read) begin
            r_rd_row <= r_mem[r_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_value <= w_hit ? r_rd_row.values[w_hit_way] : hmkv_pkg::MISS_VALUE;
            r_out_found <= w_hit;
            r_out_full  <= (r_op == hmkv_pkg::OP_PUT) && !w_hit && !w_free;
        end
    end

    assign i_req.ready       = i_cmd.idle;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.value_out   = r_out_value;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.bucket_full = r_out_full;

    always_comb begin
        o_status.req_valid = i_req.valid;
        o_status.clr_last  = (r_clr_idx ==
                              hmkv_pkg::BUCKET_BITS'(hmkv_pkg::NUM_BUCKETS - 1));
        o_status.out_free  = !r_out_valid || o_rsp.ready;
    end

endmodule

// File: rtl/hash_map_key_value_table.sv
// Request path: after a request transaction the bucket row is read, then compared and
// written back as the result is loaded; the hash is formed ahead of the accepting edge.
// A new request is taken only once the last is through; each is a read-modify-write of
// one bucket row in the single-port table memory, and the execute step holds while the
// result waits. Reset: a clearing pass writes every one of the NUM_BUCKETS (1024) bucket
// rows empty; requests are not accepted until it ends.
module hash_map_key_value_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmkv_req_if.sink   i_req,
    hmkv_rsp_if.source o_rsp
);

    hmkv_pkg::t_cmd    w_cmd;
    hmkv_pkg::t_status w_status;

    hmkv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    hmkv_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_req    (i_req),
        .o_rsp    (o_rsp)
    );

endmodule
